// ===== hdl/ssa_pkg.sv =====
// Shared types and constants for the seat slot allocator.
package ssa_pkg;

    localparam int WAGONS_DEF  = 8;
    localparam int SEATS_DEF   = 64;
    localparam int ID_BITS_DEF = 16;

    localparam int CFG_REGS   = 8;
    localparam int CFG_ADDR_W = 5;
    localparam int PDATA_W    = 32;
    localparam int CNT_W      = 7;

    localparam int ACT_W   = 2;
    localparam int PID_W   = 16;
    localparam int WAGON_W = 4;
    localparam int SEAT_W  = 7;

    typedef logic [CNT_W-1:0] seat_cnt_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_LOCATE  = 2'd1,
        ACT_RELEASE = 2'd2,
        ACT_ASSIGN  = 2'd3
    } action_t;

endpackage

// ===== hdl/ssa_if.sv =====
// Request and result channel interfaces of the seat slot allocator.
interface ssa_in_if
    import ssa_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [ACT_W-1:0]   action;
    logic [PID_W-1:0]   passenger_id;
    logic [WAGON_W-1:0] wagon;
    logic [SEAT_W-1:0]  seat;

    modport source (output valid, action, passenger_id, wagon, seat, input ready);
    modport sink   (input valid, action, passenger_id, wagon, seat, output ready);
endinterface

interface ssa_out_if
    import ssa_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               found;
    logic [WAGON_W-1:0] out_wagon;
    logic [SEAT_W-1:0]  out_seat;

    modport source (output valid, found, out_wagon, out_seat, input ready);
    modport sink   (input valid, found, out_wagon, out_seat, output ready);
endinterface

// ===== hdl/seat_slot_allocator.sv =====
// Seat slot allocator top level: slot table sequencer and count registers.
// Allocate/locate: the scan walks the slots in wagon-major order from slot 0 and answers at the first hit,
//   or with a miss after the last slot; the scan reads one table entry per cycle from a single RAM port.
// Release: read then write back, no table access if out of range; assign: a direct write. One in flight.
// A result waits in an output register; the next item is taken meanwhile.
// After reset a clearing pass writes every table entry and so frees every slot; no item is taken then.
module seat_slot_allocator
    import ssa_pkg::*;
#(
    parameter int WAGONS  = WAGONS_DEF,
    parameter int SEATS   = SEATS_DEF,
    parameter int ID_BITS = ID_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    ssa_in_if.sink                in_ch,
    ssa_out_if.source             out_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic                  pready
);

    seat_cnt_t cnt [WAGONS];

    ssa_cfg #(
        .WAGONS (WAGONS)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cnt     (cnt)
    );

    ssa_engine #(
        .WAGONS  (WAGONS),
        .SEATS   (SEATS),
        .ID_BITS (ID_BITS)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .cnt    (cnt),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

endmodule

// ===== hdl/ssa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module ssa_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/ssa_cfg.sv =====
// APB register file holding the per-wagon seat counts.
module ssa_cfg
    import ssa_pkg::*;
#(
    parameter int WAGONS = WAGONS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic                  pready,
    output seat_cnt_t             cnt [WAGONS]
);

    seat_cnt_t               cnt_reg [CFG_REGS];
    logic [CFG_ADDR_W-3:0]   reg_idx;

    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign pready  = 1'b1;
    assign prdata  = PDATA_W'(cnt_reg[reg_idx]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CFG_REGS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else if (psel && penable && pwrite)
        begin
            cnt_reg[reg_idx] <= pwdata[CNT_W-1:0];
        end
    end

    always_comb
    begin
        for (int i = 0; i < WAGONS; i++)
        begin
            cnt[i] = cnt_reg[i];
        end
    end

endmodule

// ===== hdl/ssa_engine.sv =====
// Sequencer: clearing pass, slot scans and read-modify-write on the slot table.
module ssa_engine
    import ssa_pkg::*;
#(
    parameter int WAGONS  = WAGONS_DEF,
    parameter int SEATS   = SEATS_DEF,
    parameter int ID_BITS = ID_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  seat_cnt_t  cnt [WAGONS],
    ssa_in_if.sink     in_ch,
    ssa_out_if.source  out_ch
);

    localparam int DEPTH = WAGONS * SEATS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int W_W   = (WAGONS > 1) ? $clog2(WAGONS) : 1;
    localparam int S_W   = (SEATS > 1) ? $clog2(SEATS) : 1;
    localparam int CMP_W = ((S_W > CNT_W) ? S_W : CNT_W) + 1;
    localparam int RNG_W = (SEAT_W > $clog2(SEATS + 1)) ? SEAT_W : $clog2(SEATS + 1);
    localparam int ENT_W = ID_BITS + 1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_SCAN,
        ST_RD,
        ST_CHK,
        ST_HOLD
    } state_t;

    state_t               state_reg, state_next;
    action_t              op_reg, op_next;
    logic [ID_BITS-1:0]   key_reg, key_next;
    logic [WAGON_W-1:0]   wagon_reg, wagon_next;
    logic [SEAT_W-1:0]    seat_reg, seat_next;
    logic [AW-1:0]        op_addr_reg, op_addr_next;

    logic [AW-1:0]        iaddr_reg, iaddr_next;
    logic [W_W-1:0]       iw_reg, iw_next;
    logic [S_W-1:0]       is_reg, is_next;
    logic                 issue_on_reg, issue_on_next;

    logic                 p_valid_reg, p_valid_next;
    logic [AW-1:0]        p_addr_reg, p_addr_next;
    logic [W_W-1:0]       p_w_reg, p_w_next;
    logic [S_W-1:0]       p_s_reg, p_s_next;
    logic                 p_last_reg, p_last_next;

    logic                 res_found_reg, res_found_next;
    logic [WAGON_W-1:0]   res_wagon_reg, res_wagon_next;
    logic [SEAT_W-1:0]    res_seat_reg, res_seat_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 out_found_reg, out_found_next;
    logic [WAGON_W-1:0]   out_wagon_reg, out_wagon_next;
    logic [SEAT_W-1:0]    out_seat_reg, out_seat_next;

    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [ENT_W-1:0]     ram_wdata, ram_rdata;

    logic                 ent_used;
    logic [ID_BITS-1:0]   ent_owner;
    logic                 in_range, fits_cnt, seat_fits, hit;
    logic [W_W-1:0]       w_idx;
    logic [S_W-1:0]       s_idx;
    logic [AW-1:0]        slot_addr;

    ssa_ram #(
        .WIDTH (ENT_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ent_used  = ram_rdata[ID_BITS];
    assign ent_owner = ram_rdata[ID_BITS-1:0];

    assign in_ch.ready      = (state_reg == ST_IDLE);
    assign out_ch.valid     = out_valid_reg;
    assign out_ch.found     = out_found_reg;
    assign out_ch.out_wagon = out_wagon_reg;
    assign out_ch.out_seat  = out_seat_reg;

    // explicit slot of release and assign
    assign w_idx     = W_W'(wagon_reg - WAGON_W'(1));
    assign s_idx     = S_W'(seat_reg - SEAT_W'(1));
    assign slot_addr = AW'(AW'(w_idx) * AW'(SEATS)) + AW'(s_idx);
    assign in_range  = (wagon_reg != '0) && (wagon_reg <= WAGON_W'(WAGONS))
                    && (seat_reg != '0) && (RNG_W'(seat_reg) <= RNG_W'(SEATS));
    assign fits_cnt  = in_range && (seat_reg <= cnt[w_idx]);

    // scan compare on the entry returned this cycle
    assign seat_fits = CMP_W'(p_s_reg) < CMP_W'(cnt[p_w_reg]);
    assign hit = (op_reg == ACT_ALLOC) ? (!ent_used && seat_fits)
                                       : (ent_used && (ent_owner == key_reg));

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        wagon_next     = wagon_reg;
        seat_next      = seat_reg;
        op_addr_next   = op_addr_reg;
        iaddr_next     = iaddr_reg;
        iw_next        = iw_reg;
        is_next        = is_reg;
        issue_on_next  = issue_on_reg;
        p_valid_next   = p_valid_reg;
        p_addr_next    = p_addr_reg;
        p_w_next       = p_w_reg;
        p_s_next       = p_s_reg;
        p_last_next    = p_last_reg;
        res_found_next = res_found_reg;
        res_wagon_next = res_wagon_reg;
        res_seat_next  = res_seat_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_found_next = out_found_reg;
        out_wagon_next = out_wagon_reg;
        out_seat_next  = out_seat_reg;

        ram_we    = 1'b0;
        ram_waddr = iaddr_reg;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = iaddr_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we     = 1'b1;
                iaddr_next = iaddr_reg + AW'(1);
                if (iaddr_reg == AW'(DEPTH - 1))
                begin
                    iaddr_next = '0;
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    op_next    = action_t'(in_ch.action);
                    key_next   = ID_BITS'(in_ch.passenger_id);
                    wagon_next = in_ch.wagon;
                    seat_next  = in_ch.seat;
                    state_next = ST_PREP;
                end
            end

            ST_PREP:
            begin
                op_addr_next   = slot_addr;
                res_found_next = 1'b0;
                res_wagon_next = '0;
                res_seat_next  = '0;
                iaddr_next     = '0;
                iw_next        = '0;
                is_next        = '0;
                issue_on_next  = 1'b1;
                p_valid_next   = 1'b0;
                unique case (op_reg)
                    ACT_ALLOC, ACT_LOCATE:
                    begin
                        state_next = ST_SCAN;
                    end
                    ACT_RELEASE:
                    begin
                        state_next = in_range ? ST_RD : ST_HOLD;
                    end
                    ACT_ASSIGN:
                    begin
                        if (fits_cnt)
                        begin
                            ram_we         = 1'b1;
                            ram_waddr      = slot_addr;
                            ram_wdata      = {1'b1, key_reg};
                            res_found_next = 1'b1;
                            res_wagon_next = wagon_reg;
                            res_seat_next  = seat_reg;
                        end
                        state_next = ST_HOLD;
                    end
                endcase
            end

            ST_SCAN:
            begin
                p_valid_next = issue_on_reg;
                if (issue_on_reg)
                begin
                    ram_re      = 1'b1;
                    p_addr_next = iaddr_reg;
                    p_w_next    = iw_reg;
                    p_s_next    = is_reg;
                    p_last_next = (iaddr_reg == AW'(DEPTH - 1));
                    iaddr_next  = iaddr_reg + AW'(1);
                    if (is_reg == S_W'(SEATS - 1))
                    begin
                        is_next = '0;
                        iw_next = iw_reg + W_W'(1);
                    end
                    else
                    begin
                        is_next = is_reg + S_W'(1);
                    end
                    if (iaddr_reg == AW'(DEPTH - 1))
                    begin
                        issue_on_next = 1'b0;
                    end
                end
                if (p_valid_reg)
                begin
                    if (hit)
                    begin
                        if (op_reg == ACT_ALLOC)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = p_addr_reg;
                            ram_wdata = {1'b1, key_reg};
                        end
                        res_found_next = 1'b1;
                        res_wagon_next = WAGON_W'(p_w_reg) + WAGON_W'(1);
                        res_seat_next  = SEAT_W'(p_s_reg) + SEAT_W'(1);
                        issue_on_next  = 1'b0;
                        state_next     = ST_HOLD;
                    end
                    else if (p_last_reg)
                    begin
                        state_next = ST_HOLD;
                    end
                end
            end

            ST_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = op_addr_reg;
                state_next = ST_CHK;
            end

            ST_CHK:
            begin
                if (ent_used)
                begin
                    ram_we         = 1'b1;
                    ram_waddr      = op_addr_reg;
                    ram_wdata      = {1'b0, ent_owner};
                    res_found_next = 1'b1;
                    res_wagon_next = wagon_reg;
                    res_seat_next  = seat_reg;
                end
                state_next = ST_HOLD;
            end

            ST_HOLD:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = res_found_reg;
                    out_wagon_next = res_wagon_reg;
                    out_seat_next  = res_seat_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            op_reg        <= ACT_ALLOC;
            key_reg       <= '0;
            wagon_reg     <= '0;
            seat_reg      <= '0;
            op_addr_reg   <= '0;
            iaddr_reg     <= '0;
            iw_reg        <= '0;
            is_reg        <= '0;
            issue_on_reg  <= 1'b0;
            p_valid_reg   <= 1'b0;
            p_addr_reg    <= '0;
            p_w_reg       <= '0;
            p_s_reg       <= '0;
            p_last_reg    <= 1'b0;
            res_found_reg <= 1'b0;
            res_wagon_reg <= '0;
            res_seat_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_found_reg <= 1'b0;
            out_wagon_reg <= '0;
            out_seat_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            key_reg       <= key_next;
            wagon_reg     <= wagon_next;
            seat_reg      <= seat_next;
            op_addr_reg   <= op_addr_next;
            iaddr_reg     <= iaddr_next;
            iw_reg        <= iw_next;
            is_reg        <= is_next;
            issue_on_reg  <= issue_on_next;
            p_valid_reg   <= p_valid_next;
            p_addr_reg    <= p_addr_next;
            p_w_reg       <= p_w_next;
            p_s_reg       <= p_s_next;
            p_last_reg    <= p_last_next;
            res_found_reg <= res_found_next;
            res_wagon_reg <= res_wagon_next;
            res_seat_reg  <= res_seat_next;
            out_valid_reg <= out_valid_next;
            out_found_reg <= out_found_next;
            out_wagon_reg <= out_wagon_next;
            out_seat_reg  <= out_seat_next;
        end
    end

endmodule

// ===== verif/tb_seat_slot_allocator.sv =====
// Self-checking testbench for the seat slot allocator: booking requests in, seat answers out.
module tb_seat_slot_allocator
    import ssa_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS           = WAGONS_DEF * SEATS_DEF;
    localparam int N_PHASES        = 4;
    localparam int ITEMS_PER_PHASE = 100;

    typedef struct packed {
        action_t              action;
        logic [PID_W-1:0]     pid;
        logic [WAGON_W-1:0]   wagon;
        logic [SEAT_W-1:0]    seat;
    } booking_t;

    typedef struct packed {
        logic                 found;
        logic [WAGON_W-1:0]   wagon;
        logic [SEAT_W-1:0]    seat;
    } seat_answer_t;

    typedef seat_cnt_t count_set_t [CFG_REGS];

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [PDATA_W-1:0]    pwdata;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    ssa_in_if  req_ch ();
    ssa_out_if ans_ch ();

    booking_t         pend_q [$];
    seat_answer_t     exp_q [$];

    int               cnt_m [CFG_REGS];
    logic             used_m [SLOTS];
    logic [PID_W-1:0] owner_m [SLOTS];

    int               gap_cnt;
    int               stall_cnt;
    booking_t         drv_bk;
    booking_t         mon_bk;
    seat_answer_t     mon_exp;
    seat_answer_t     mon_act;

    int               n_err;
    int               n_acc;
    int               n_checked;
    int               n_found;
    int               n_act [4];

    seat_slot_allocator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (req_ch),
        .out_ch  (ans_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 clk = ~clk;

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
        begin
            return 0;
        end
        else if (roll < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic booking_t rand_booking();
        booking_t b;
        int       roll;
        roll = $urandom_range(0, 99);
        if (roll < 35)
        begin
            b.action = ACT_ALLOC;
        end
        else if (roll < 60)
        begin
            b.action = ACT_LOCATE;
        end
        else if (roll < 80)
        begin
            b.action = ACT_RELEASE;
        end
        else
        begin
            b.action = ACT_ASSIGN;
        end
        if ($urandom_range(0, 9) < 8)
        begin
            b.pid = PID_W'($urandom_range(1, 12));
        end
        else
        begin
            b.pid = PID_W'($urandom());
        end
        if ($urandom_range(0, 19) == 0)
        begin
            b.wagon = WAGON_W'($urandom_range(0, 15));
        end
        else
        begin
            b.wagon = WAGON_W'($urandom_range(1, WAGONS_DEF));
        end
        roll = $urandom_range(0, 19);
        if (roll == 0)
        begin
            b.seat = SEAT_W'($urandom_range(0, 127));
        end
        else if (roll < 5)
        begin
            b.seat = SEAT_W'($urandom_range(1, SEATS_DEF));
        end
        else
        begin
            b.seat = SEAT_W'($urandom_range(1, 8));
        end
        return b;
    endfunction

    function automatic int wagon_seats(input int w);
        return (cnt_m[w] > SEATS_DEF) ? SEATS_DEF : cnt_m[w];
    endfunction

    function automatic seat_answer_t predict(input booking_t b);
        seat_answer_t r;
        int           w;
        int           s;
        int           k;
        int           wg;
        int           st;
        r  = '0;
        wg = int'(b.wagon);
        st = int'(b.seat);
        case (b.action)
            ACT_ALLOC:
            begin
                for (w = 0; w < WAGONS_DEF; w++)
                begin
                    for (s = 0; s < wagon_seats(w); s++)
                    begin
                        k = w * SEATS_DEF + s;
                        if (!used_m[k])
                        begin
                            used_m[k]  = 1'b1;
                            owner_m[k] = b.pid;
                            r.found    = 1'b1;
                            r.wagon    = WAGON_W'(w + 1);
                            r.seat     = SEAT_W'(s + 1);
                            return r;
                        end
                    end
                end
            end
            ACT_LOCATE:
            begin
                for (k = 0; k < SLOTS; k++)
                begin
                    if (used_m[k] && (owner_m[k] == b.pid))
                    begin
                        r.found = 1'b1;
                        r.wagon = WAGON_W'(k / SEATS_DEF + 1);
                        r.seat  = SEAT_W'(k % SEATS_DEF + 1);
                        return r;
                    end
                end
            end
            default:
            begin
                if (wg >= 1 && wg <= WAGONS_DEF && st >= 1 && st <= SEATS_DEF)
                begin
                    k = (wg - 1) * SEATS_DEF + (st - 1);
                    if (b.action == ACT_RELEASE)
                    begin
                        if (used_m[k])
                        begin
                            used_m[k] = 1'b0;
                            r.found   = 1'b1;
                            r.wagon   = b.wagon;
                            r.seat    = b.seat;
                        end
                    end
                    else if (st <= wagon_seats(wg - 1))
                    begin
                        used_m[k]  = 1'b1;
                        owner_m[k] = b.pid;
                        r.found    = 1'b1;
                        r.wagon    = b.wagon;
                        r.seat     = b.seat;
                    end
                end
            end
        endcase
        return r;
    endfunction

    task automatic apb_write(input int idx, input logic [PDATA_W-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(idx * 4);
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        cnt_m[idx] = int'(val[CNT_W-1:0]);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input int idx, output logic [PDATA_W-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= CFG_ADDR_W'(idx * 4);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        val = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic drain();
        while (pend_q.size() != 0 || req_ch.valid || exp_q.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_ch.valid        <= 1'b0;
            req_ch.action       <= '0;
            req_ch.passenger_id <= '0;
            req_ch.wagon        <= '0;
            req_ch.seat         <= '0;
            gap_cnt = 0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (gap_cnt > 0)
            begin
                gap_cnt--;
                req_ch.valid <= 1'b0;
            end
            else if (pend_q.size() > 0)
            begin
                drv_bk = pend_q.pop_front();
                req_ch.valid        <= 1'b1;
                req_ch.action       <= drv_bk.action;
                req_ch.passenger_id <= drv_bk.pid;
                req_ch.wagon        <= drv_bk.wagon;
                req_ch.seat         <= drv_bk.seat;
                gap_cnt = pick_gap();
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // answer backpressure
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            ans_ch.ready <= 1'b0;
            stall_cnt = 0;
        end
        else if (stall_cnt > 0)
        begin
            stall_cnt--;
            ans_ch.ready <= 1'b0;
        end
        else
        begin
            ans_ch.ready <= 1'b1;
            stall_cnt = pick_gap();
        end
    end

    // monitor and checker
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                mon_bk.action = action_t'(req_ch.action);
                mon_bk.pid    = req_ch.passenger_id;
                mon_bk.wagon  = req_ch.wagon;
                mon_bk.seat   = req_ch.seat;
                exp_q.push_back(predict(mon_bk));
                n_act[req_ch.action]++;
                n_acc++;
            end
            if (ans_ch.valid && ans_ch.ready)
            begin
                mon_act.found = ans_ch.found;
                mon_act.wagon = ans_ch.out_wagon;
                mon_act.seat  = ans_ch.out_seat;
                if (exp_q.size() == 0)
                begin
                    $display("%0t: unexpected item, expected none, actual found=%0d wagon=%0d seat=%0d",
                             $time, mon_act.found, mon_act.wagon, mon_act.seat);
                    n_err++;
                end
                else
                begin
                    mon_exp = exp_q.pop_front();
                    if (mon_act !== mon_exp)
                    begin
                        $display("%0t: mismatch, expected found=%0d wagon=%0d seat=%0d",
                                 $time, mon_exp.found, mon_exp.wagon, mon_exp.seat);
                        $display("%0t:           actual   found=%0d wagon=%0d seat=%0d",
                                 $time, mon_act.found, mon_act.wagon, mon_act.seat);
                        n_err++;
                    end
                    if (mon_exp.found)
                    begin
                        n_found++;
                    end
                    n_checked++;
                end
            end
        end
    end

    initial
    begin
        count_set_t         cs;
        logic [PDATA_W-1:0] rd_val;
        int                 phase;
        int                 i;
        int                 j;
        rst_n     = 1'b0;
        n_err     = 0;
        n_acc     = 0;
        n_checked = 0;
        n_found   = 0;
        for (i = 0; i < 4; i++)
        begin
            n_act[i] = 0;
        end
        for (i = 0; i < CFG_REGS; i++)
        begin
            cnt_m[i] = 0;
        end
        for (i = 0; i < SLOTS; i++)
        begin
            used_m[i]  = 1'b0;
            owner_m[i] = '0;
        end
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (phase = 0; phase < N_PHASES; phase++)
        begin
            drain();
            case (phase)
                0:
                begin
                    cs = '{7'd2, 7'd0, 7'd3, 7'd1, 7'd0, 7'd0, 7'd2, 7'd1};
                end
                1:
                begin
                    cs = '{7'd64, 7'd100, 7'd0, 7'd5, 7'd127, 7'd0, 7'd10, 7'd3};
                end
                2:
                begin
                    cs = '{7'd1, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd2};
                end
                default:
                begin
                    for (i = 0; i < CFG_REGS; i++)
                    begin
                        if ($urandom_range(0, 3) == 0)
                        begin
                            cs[i] = '0;
                        end
                        else
                        begin
                            cs[i] = seat_cnt_t'($urandom_range(1, 127));
                        end
                    end
                end
            endcase
            for (i = 0; i < CFG_REGS; i++)
            begin
                apb_write(i, PDATA_W'({$urandom(), cs[i]}));
            end
            for (i = 0; i < CFG_REGS; i++)
            begin
                apb_read(i, rd_val);
                if (rd_val !== PDATA_W'(cnt_m[i]))
                begin
                    $display("%0t: register %0d mismatch, expected %0d, actual %0d",
                             $time, i, cnt_m[i], rd_val);
                    n_err++;
                end
            end
            for (j = 0; j < ITEMS_PER_PHASE; j++)
            begin
                pend_q.push_back(rand_booking());
            end
        end
        drain();

        $display("Ran %0d booking items over %0d seat-count settings: %0d allocate, %0d locate,",
                 n_acc, N_PHASES, n_act[ACT_ALLOC], n_act[ACT_LOCATE]);
        $display("%0d release, %0d assign; %0d answers carried a seat, %0d checked.",
                 n_act[ACT_RELEASE], n_act[ACT_ASSIGN], n_found, n_checked);
        if (n_err == 0 && n_checked == n_acc)
        begin
            $display("** seat_slot_allocator: PASSED **");
        end
        else
        begin
            $display("** seat_slot_allocator: FAILED **");
        end
        $finish;
    end

    initial
    begin
        #(20_000_000);
        $display("%0t: run did not finish in time", $time);
        $display("** seat_slot_allocator: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/ssa_pkg.sv
hdl/ssa_if.sv
hdl/ssa_ram.sv
hdl/ssa_cfg.sv
hdl/ssa_engine.sv
hdl/seat_slot_allocator.sv
verif/tb_seat_slot_allocator.sv
